// File: src/two_class_fifo_oldest_select_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the two-class FIFO.
// ---------------------------------------------------------------------------
`ifndef TWO_CLASS_FIFO_OLDEST_SELECT_CORE_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_SELECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCFO_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcfo assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCFO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcfo assertion failed");

// Next-cycle implication that is also checked across reset.
`define TCFO_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tcfo assertion failed");

`endif

// File: src/tcfo_pkg.sv
// ---------------------------------------------------------------------------
// tcfo_pkg
// Shared codes and types of the two-class FIFO with oldest-item selection.
// ---------------------------------------------------------------------------
package tcfo_pkg;

  // Command codes on the cmd input.
  localparam logic [1:0] CMD_ENQUEUE   = 2'd0;
  localparam logic [1:0] CMD_OLDEST    = 2'd1;
  localparam logic [1:0] CMD_OLDEST_C0 = 2'd2;
  localparam logic [1:0] CMD_OLDEST_C1 = 2'd3;

  // Status codes on the status output.
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Decoded operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ENQ,
    OP_REM_ANY,
    OP_REM_C0,
    OP_REM_C1
  } op_t;

  typedef struct packed {
    op_t  op;
    logic cls;
  } cmd_req_t;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

// File: src/tcfo_ram.sv
// ---------------------------------------------------------------------------
// tcfo_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
module tcfo_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tcfo_front.sv
// ---------------------------------------------------------------------------
// tcfo_front
// Accepts requests, decodes the command and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module tcfo_front #(
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd,
  input  logic                    item_class,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic                    req_valid,
  output tcfo_pkg::cmd_req_t      req,
  output logic [PAYLOAD_BITS-1:0] req_payload,
  input  logic                    req_take
);

  tcfo_pkg::cmd_req_t      slot_req [2];
  logic [PAYLOAD_BITS-1:0] slot_pay [2];
  logic [1:0]              fill;
  tcfo_pkg::cmd_req_t      dec;
  logic                    accept;

  always_comb begin
    dec.cls = item_class;
    case (cmd)
      tcfo_pkg::CMD_ENQUEUE:   dec.op = tcfo_pkg::OP_ENQ;
      tcfo_pkg::CMD_OLDEST:    dec.op = tcfo_pkg::OP_REM_ANY;
      tcfo_pkg::CMD_OLDEST_C0: dec.op = tcfo_pkg::OP_REM_C0;
      tcfo_pkg::CMD_OLDEST_C1: dec.op = tcfo_pkg::OP_REM_C1;
      default:                 dec.op = tcfo_pkg::OP_ENQ;
    endcase
  end

  assign full        = (fill == 2'd2);
  assign accept      = push && !full;
  assign req_valid   = (fill != 2'd0);
  assign req         = slot_req[0];
  assign req_payload = slot_pay[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (accept && !req_take) begin
      fill <= fill + 2'd1;
    end else if (!accept && req_take) begin
      fill <= fill - 2'd1;
    end
  end

  // Slot 0 is always the oldest waiting request.
  always_ff @(posedge clk) begin
    if (req_take) begin
      if (accept && fill == 2'd1) begin
        slot_req[0] <= dec;
        slot_pay[0] <= payload;
      end else begin
        slot_req[0] <= slot_req[1];
        slot_pay[0] <= slot_pay[1];
      end
      if (accept && fill == 2'd2) begin
        slot_req[1] <= dec;
        slot_pay[1] <= payload;
      end
    end else if (accept) begin
      if (fill == 2'd0) begin
        slot_req[0] <= dec;
        slot_pay[0] <= payload;
      end else begin
        slot_req[1] <= dec;
        slot_pay[1] <= payload;
      end
    end
  end

endmodule

// File: src/tcfo_back.sv
// ---------------------------------------------------------------------------
// tcfo_back
// Executes requests on the two class queues and holds one finished result.
// ---------------------------------------------------------------------------
module tcfo_back #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  tcfo_pkg::cmd_req_t      req,
  input  logic [PAYLOAD_BITS-1:0] req_payload,
  output logic                    req_take,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              status,
  output logic [PAYLOAD_BITS-1:0] payload_out,
  output logic                    class_out
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STAMP_W = IDX_W + 2;
  localparam int ENTRY_W = PAYLOAD_BITS + STAMP_W;

  tcfo_pkg::back_state_t state, state_next;

  logic [CNT_W-1:0]   count [2];
  logic [IDX_W-1:0]   head  [2];
  logic [STAMP_W-1:0] arrival;
  logic [ENTRY_W-1:0] rd_data [2];

  logic               res_valid;
  logic               res_free;
  logic               res_load;
  logic [1:0]         status_next;
  logic               enq_do;
  logic               rem_do;
  logic               pick;
  logic               has0, has1;
  logic               enq_full;
  logic [IDX_W:0]     tail_sum;
  logic [IDX_W-1:0]   tail;
  logic [STAMP_W-1:0] stamp_diff;
  logic               c0_older;

  assign res_free = !res_valid || pop;
  assign has0     = (count[0] != '0);
  assign has1     = (count[1] != '0);
  assign enq_full = (count[req.cls] == CNT_W'(QUEUE_DEPTH));

  // Tail slot of the enqueue class, head plus fill wrapped once.
  assign tail_sum = (IDX_W + 1)'(head[req.cls]) + (IDX_W + 1)'(count[req.cls]);
  assign tail     = (tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - (IDX_W + 1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

  // Wrap-around age compare of the two head stamps.
  assign stamp_diff = rd_data[1][ENTRY_W-1 -: STAMP_W] - rd_data[0][ENTRY_W-1 -: STAMP_W];
  assign c0_older   = (stamp_diff != '0) && !stamp_diff[STAMP_W-1];

  for (genvar c = 0; c < 2; c++) begin : g_lane
    tcfo_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (enq_do && (req.cls == 1'(c))),
      .waddr (tail),
      .wdata ({arrival, req_payload}),
      .raddr (head[c]),
      .rdata (rd_data[c])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      tcfo_pkg::BK_IDLE: begin
        if (req_valid && res_free && req.op != tcfo_pkg::OP_ENQ) begin
          state_next = tcfo_pkg::BK_READ;
        end
      end
      tcfo_pkg::BK_READ: state_next = tcfo_pkg::BK_IDLE;
      default:           state_next = tcfo_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    req_take    = 1'b0;
    res_load    = 1'b0;
    enq_do      = 1'b0;
    rem_do      = 1'b0;
    pick        = 1'b0;
    status_next = tcfo_pkg::ST_EMPTY;
    case (state)
      tcfo_pkg::BK_IDLE: begin
        if (req_valid && res_free && req.op == tcfo_pkg::OP_ENQ) begin
          req_take = 1'b1;
          res_load = 1'b1;
          if (enq_full) begin
            status_next = tcfo_pkg::ST_FULL;
          end else begin
            enq_do      = 1'b1;
            status_next = tcfo_pkg::ST_ENQUEUED;
          end
        end
      end
      tcfo_pkg::BK_READ: begin
        req_take = 1'b1;
        res_load = 1'b1;
        case (req.op)
          tcfo_pkg::OP_REM_C0: begin
            rem_do = has0;
            pick   = 1'b0;
          end
          tcfo_pkg::OP_REM_C1: begin
            rem_do = has1;
            pick   = 1'b1;
          end
          tcfo_pkg::OP_REM_ANY: begin
            rem_do = has0 || has1;
            pick   = (has0 && has1) ? !c0_older : has1;
          end
          default: begin
            rem_do = 1'b0;
            pick   = 1'b0;
          end
        endcase
        if (rem_do) begin
          status_next = tcfo_pkg::ST_REMOVED;
        end
      end
      default: begin
        req_take = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcfo_pkg::BK_IDLE;
      res_valid <= 1'b0;
      count[0]  <= '0;
      count[1]  <= '0;
      head[0]   <= '0;
      head[1]   <= '0;
      arrival   <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      if (enq_do) begin
        count[req.cls] <= count[req.cls] + CNT_W'(1);
        arrival        <= arrival + STAMP_W'(1);
      end
      if (rem_do) begin
        count[pick] <= count[pick] - CNT_W'(1);
        head[pick]  <= (head[pick] == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head[pick] + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status      <= status_next;
      payload_out <= rem_do ? rd_data[pick][PAYLOAD_BITS-1:0] : '0;
      class_out   <= rem_do ? pick : 1'b0;
    end
  end

  assign empty = !res_valid;

endmodule

// File: src/two_class_fifo_oldest_select_core.sv
// An enqueue result passes the request queue and the result register; a removal also
// passes the BK_READ state. Enqueues go at one per cycle while the result register is
// free; a removal waits in BK_READ for the registered read of the head entries.
// A two-entry request queue and a one-entry result register decouple the two sides.
// Reset (rst, synchronous, active high) empties both class queues, both internal
// queues and zeroes the arrival stamp; the class memories need no clearing pass.
// ---------------------------------------------------------------------------
// two_class_fifo_oldest_select_core
// Two per-class FIFOs sharing one arrival stamp, with removal of the oldest
// item of a given class or of either class.
// ---------------------------------------------------------------------------
module two_class_fifo_oldest_select_core #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // Request side: a request is taken when push is high and full is low.
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd,
  input  logic                    item_class,
  input  logic [PAYLOAD_BITS-1:0] payload,
  // Result side: the oldest result is shown while empty is low and leaves on pop.
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              status,
  output logic [PAYLOAD_BITS-1:0] payload_out,
  output logic                    class_out
);

  // The front decodes each request into an operation and buffers it, so the
  // requester can keep pushing while the back end is busy with a removal.
  logic                    req_valid;
  logic                    req_take;
  tcfo_pkg::cmd_req_t      req;
  logic [PAYLOAD_BITS-1:0] req_payload;

  tcfo_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .item_class  (item_class),
    .payload     (payload),
    .req_valid   (req_valid),
    .req         (req),
    .req_payload (req_payload),
    .req_take    (req_take)
  );

  // The back end owns the class memories, heads, fill counts and the arrival
  // stamp. Enqueues finish in the cycle they are taken. Removals first read
  // both head entries, then compare their stamps with wrap-around arithmetic
  // and pop the chosen class. Each finished request lands in the result
  // register, which frees in the same cycle it is popped.
  tcfo_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .req_payload (req_payload),
    .req_take    (req_take),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .payload_out (payload_out),
    .class_out   (class_out)
  );

endmodule

// File: src/tcfo_checker.sv
// ---------------------------------------------------------------------------
// tcfo_checker
// Port-level checks of the two-class FIFO, attached by bind.
// ---------------------------------------------------------------------------
`include "two_class_fifo_oldest_select_core_defines.svh"

module tcfo_checker #(
  parameter int PAYLOAD_BITS = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    push,
  input logic                    full,
  input logic                    pop,
  input logic                    empty,
  input logic [1:0]              status,
  input logic [PAYLOAD_BITS-1:0] payload_out,
  input logic                    class_out
);

  // Reset leaves both sides idle: room for requests, no result shown.
  `TCFO_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, empty && !full)

  // A result that is not a removal carries no handle and no class.
  `TCFO_ASSERT_IMPL(a_no_removal_zero, clk, rst, !empty && status != tcfo_pkg::ST_REMOVED, payload_out == '0 && class_out == 1'b0)

  // A waiting result stays put until it is popped.
  `TCFO_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(status) && $stable(payload_out) && $stable(class_out))

  // A full request queue with nothing pushed only drains by handing a request
  // to the back end, and that always leaves a result on the result ports.
  `TCFO_ASSERT_NEXT(a_push_free_full, clk, rst, full && !push, full || !empty)

endmodule

bind two_class_fifo_oldest_select_core tcfo_checker #(
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_tcfo_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .pop         (pop),
  .empty       (empty),
  .status      (status),
  .payload_out (payload_out),
  .class_out   (class_out)
);

// File: tb/two_class_fifo_oldest_select_core_test.sv
// ---------------------------------------------------------------------------
// two_class_fifo_oldest_select_core_test
// Self-checking bench for the two-class FIFO with oldest-item selection. A
// scoreboard tracks both class queues and the shared arrival stamp, works out
// the result of every accepted request, and checks the results in order.
// ---------------------------------------------------------------------------
module two_class_fifo_oldest_select_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int PAYLOAD_W  = 16;
  localparam int STAMP_W    = 6;
  localparam logic [STAMP_W-1:0] STAMP_HALF = 1 << (STAMP_W - 1);

  localparam int RANDOM_ITEMS   = 1500;
  localparam int FLOOD_AT       = 400;  // request index where the receiver holds off
  localparam int FLOOD_ITEMS    = 80;   // enqueues offered while the receiver holds off
  localparam int DRAIN_AT       = 900;  // request index where the sender waits for a drain
  localparam int HOLDOFF_CYCLES = 300;

  // One stored entry of a class queue: the handle and its arrival stamp.
  typedef struct packed {
    logic [PAYLOAD_W-1:0] handle;
    logic [STAMP_W-1:0]   stamp;
  } held_item_t;

  // One result as the block shows it on the result ports.
  typedef struct packed {
    logic [1:0]           status;
    logic [PAYLOAD_W-1:0] handle;
    logic                 cls;
  } removal_result_t;

  // The scoreboard mirrors both class queues and the arrival stamp. Each
  // accepted request is applied to that mirror at once, and the result it
  // must produce is queued until the block hands it out.
  class oldest_select_scoreboard;
    held_item_t        class0_items[$];
    held_item_t        class1_items[$];
    logic [STAMP_W-1:0] next_stamp;
    removal_result_t   expected_results[$];
    int                mismatches;

    function new();
      next_stamp = '0;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(logic [1:0] c, logic cls, logic [PAYLOAD_W-1:0] pay);
      removal_result_t r;
      held_item_t      item;
      logic [STAMP_W-1:0] gap;
      int              pick;
      r    = '{status: tcfo_pkg::ST_EMPTY, handle: '0, cls: 1'b0};
      pick = -1;
      item = '{handle: pay, stamp: next_stamp};
      case (c)
        tcfo_pkg::CMD_ENQUEUE: begin
          if ((cls ? class1_items.size() : class0_items.size()) >= DEPTH) begin
            r.status = tcfo_pkg::ST_FULL;
          end else begin
            if (cls) class1_items.push_back(item);
            else     class0_items.push_back(item);
            next_stamp = next_stamp + STAMP_W'(1);
            r.status = tcfo_pkg::ST_ENQUEUED;
          end
        end
        tcfo_pkg::CMD_OLDEST_C0: begin
          if (class0_items.size() != 0) pick = 0;
        end
        tcfo_pkg::CMD_OLDEST_C1: begin
          if (class1_items.size() != 0) pick = 1;
        end
        default: begin
          // Oldest of either class: with both heads present, the stamps are
          // compared modulo the counter range so that a wrap does not
          // reverse the order.
          if (class0_items.size() != 0 && class1_items.size() != 0) begin
            gap  = class1_items[0].stamp - class0_items[0].stamp;
            pick = (gap != 0 && gap < STAMP_HALF) ? 0 : 1;
          end else if (class0_items.size() != 0) begin
            pick = 0;
          end else if (class1_items.size() != 0) begin
            pick = 1;
          end
        end
      endcase
      if (c != tcfo_pkg::CMD_ENQUEUE && pick >= 0) begin
        item     = (pick == 1) ? class1_items.pop_front() : class0_items.pop_front();
        r.status = tcfo_pkg::ST_REMOVED;
        r.handle = item.handle;
        r.cls    = (pick == 1);
      end
      expected_results.push_back(r);
    endfunction

    task check_result(logic [1:0] st, logic [PAYLOAD_W-1:0] pay, logic cls);
      removal_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with none expected: status %0d payload %h class %0d",
                         st, pay, cls));
        return;
      end
      want = expected_results.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (pay !== want.handle)
        report($sformatf("payload_out %h, expected %h", pay, want.handle));
      if (cls !== want.cls)
        report($sformatf("class_out %0d, expected %0d", cls, want.cls));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [1:0]           cmd;
  logic                 item_class;
  logic [PAYLOAD_W-1:0] payload;
  logic                 empty;
  logic                 pop;
  logic [1:0]           status;
  logic [PAYLOAD_W-1:0] payload_out;
  logic                 class_out;

  oldest_select_scoreboard sb;

  // The sender asks for a receiver hold-off by raising holdoff_asks; the
  // receiver counts the ones it has served in holdoff_done. Each counter has
  // one writer.
  int holdoff_asks = 0;
  int holdoff_done = 0;

  two_class_fifo_oldest_select_core #(
    .QUEUE_DEPTH (DEPTH),
    .PAYLOAD_BITS(PAYLOAD_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .item_class (item_class),
    .payload    (payload),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .payload_out(payload_out),
    .class_out  (class_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one request and returns at the edge where it is taken. Push is
  // left high so that a following request can go out back to back; the
  // caller lowers it through idle_for when a gap is wanted.
  task automatic send_request(input logic [1:0] c, input logic cls,
                              input logic [PAYLOAD_W-1:0] pay);
    push       <= 1'b1;
    cmd        <= c;
    item_class <= cls;
    payload    <= pay;
    do @(posedge clk); while (full);
    sb.note_request(c, cls, pay);
  endtask

  // A gap on the request side. The fields carry noise while push is low,
  // since the block has to ignore them.
  task automatic idle_for(input int cycles);
    push       <= 1'b0;
    cmd        <= 2'($urandom);
    item_class <= 1'($urandom);
    payload    <= PAYLOAD_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering requests until every expected result has been taken.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return PAYLOAD_W'($urandom);
    endcase
  endfunction

  // Request side: reset, a short directed sequence, then phases of random
  // requests with their own mix of commands, class bias and burst shape.
  initial begin : sender
    int   enq_weight;
    int   c1_weight;
    int   phase_left;
    int   burst_left;
    int   flood_left;
    bit   steady;
    logic [1:0] c;
    logic cls;

    sb         = new();
    rst        <= 1'b1;
    push       <= 1'b0;
    cmd        <= tcfo_pkg::CMD_ENQUEUE;
    item_class <= 1'b0;
    payload    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Removals from empty queues, for each kind of removal.
    send_request(tcfo_pkg::CMD_OLDEST, 1'b0, '0);
    send_request(tcfo_pkg::CMD_OLDEST_C0, 1'b1, '1);
    send_request(tcfo_pkg::CMD_OLDEST_C1, 1'b0, '0);
    // Class 1 arrives first, so the oldest-any removal has to pick it.
    send_request(tcfo_pkg::CMD_ENQUEUE, 1'b1, '1);
    send_request(tcfo_pkg::CMD_ENQUEUE, 1'b0, '0);
    // Fill class 0 to its depth, then try one more, which is refused.
    for (int k = 1; k < DEPTH; k++)
      send_request(tcfo_pkg::CMD_ENQUEUE, 1'b0, PAYLOAD_W'(16'h1000 + 16'h0111 * k));
    send_request(tcfo_pkg::CMD_ENQUEUE, 1'b0, 16'h1234);
    send_request(tcfo_pkg::CMD_OLDEST, 1'b0, '0);
    send_request(tcfo_pkg::CMD_OLDEST_C1, 1'b1, '0);
    send_request(tcfo_pkg::CMD_OLDEST, 1'b1, '1);
    wait_for_drain();

    phase_left = 0;
    burst_left = 0;
    flood_left = 0;
    enq_weight = 50;
    c1_weight  = 50;
    steady     = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 150);
        case ($urandom_range(0, 3))
          0:       enq_weight = 25;
          1:       enq_weight = 80;
          default: enq_weight = 50;
        endcase
        c1_weight = $urandom_range(0, 100);
        steady    = ($urandom_range(0, 3) == 0);
      end
      phase_left--;

      // Long receiver hold-off while enqueues keep coming, so that the block's own
      // request queue fills and full rises.
      if (i == FLOOD_AT) begin
        holdoff_asks++;
        flood_left = FLOOD_ITEMS;
      end
      if (i == DRAIN_AT) wait_for_drain();

      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!steady && flood_left == 0 && $urandom_range(0, 3) != 0)
          idle_for($urandom_range(1, 8));
      end
      burst_left--;

      if (flood_left > 0 || $urandom_range(0, 99) < enq_weight) begin
        c = tcfo_pkg::CMD_ENQUEUE;
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    c = tcfo_pkg::CMD_OLDEST;
          2:       c = tcfo_pkg::CMD_OLDEST_C0;
          default: c = tcfo_pkg::CMD_OLDEST_C1;
        endcase
      end
      cls = ($urandom_range(0, 99) < c1_weight);
      if (flood_left > 0) flood_left--;
      send_request(c, cls, pick_payload());
    end

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: every result taken is checked, and pop follows a stall
  // pattern that changes mode from time to time, apart from the hold-off.
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    int holdoff_left;
    bit next_pop;

    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    holdoff_left = 0;
    pop          <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pop && !empty) sb.check_result(status, payload_out, class_out);

      if (holdoff_done != holdoff_asks) begin
        holdoff_done++;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        next_pop = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0:       next_pop = 1'b1;
          1:       next_pop = 1'($urandom_range(0, 1));
          2:       next_pop = (tick % 3 != 0);
          default: next_pop = ($urandom_range(0, 7) == 0);
        endcase
      end
      pop <= next_pop;
      @(posedge clk);
    end
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
